// File: hdl/cfsv_pkg.sv
// ---------------------------------------------------------------------------
// cfsv_pkg
// Shared types and constants of the cube face to sphere vertex generator.
// ---------------------------------------------------------------------------
`default_nettype none

package cfsv_pkg;

  // register indexes
  localparam logic REG_GRID_DIV = 1'b0;
  localparam logic REG_FACE     = 1'b1;

  // face codes
  localparam logic [2:0] FACE_FRONT = 3'd0;
  localparam logic [2:0] FACE_BACK  = 3'd1;
  localparam logic [2:0] FACE_LEFT  = 3'd2;
  localparam logic [2:0] FACE_RIGHT = 3'd3;
  localparam logic [2:0] FACE_UP    = 3'd4;
  localparam logic [2:0] FACE_DOWN  = 3'd5;

  // corner codes: bit0 column offset, bit1 row offset
  localparam logic [1:0] C_L  = 2'd0;
  localparam logic [1:0] C_LN = 2'd1;
  localparam logic [1:0] C_U  = 2'd2;
  localparam logic [1:0] C_UN = 2'd3;

  localparam logic [1:0] WIND_A [6] = '{C_U, C_UN, C_L, C_L, C_UN, C_LN};
  localparam logic [1:0] WIND_B [6] = '{C_U, C_L, C_UN, C_L, C_LN, C_UN};

  // output fraction bits (Q2.14); the root stages are sized for this
  localparam int COORD_FRAC_BITS = 14;

  localparam int NUM_W     = 53;
  localparam int DEN_W     = 51;
  localparam int FRONT_LAT = 5;
  localparam int SQRT_LAT  = 16;
  localparam logic [15:0] SAT_MAG = 16'h7fff;

  typedef logic signed [9:0] coord_t;

  typedef struct packed {
    coord_t     px;
    coord_t     py;
    coord_t     pz;
    logic [8:0] n;
  } vtx_coord_t;

  typedef struct packed {
    logic       valid;
    logic       tri_idx;
    logic [1:0] corner;
    logic       last;
  } vtx_meta_t;

endpackage

`default_nettype wire

// File: hdl/cfsv_cell_if.sv
// ---------------------------------------------------------------------------
// cfsv_cell_if
// Cell channel: one grid cell per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfsv_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_row;
  logic [7:0] cell_col;

  modport source (output valid, cell_row, cell_col, input ready);
  modport sink   (input valid, cell_row, cell_col, output ready);
endinterface

`default_nettype wire

// File: hdl/cfsv_vtx_if.sv
// ---------------------------------------------------------------------------
// cfsv_vtx_if
// Vertex channel: one sphere vertex per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfsv_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic               tri_index;
  logic [1:0]         corner_index;
  logic               last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, tri_index, corner_index,
                  last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tri_index, corner_index,
                  last_vertex, output ready);
endinterface

`default_nettype wire

// File: hdl/cube_face_sphere_vertex_gen.sv
// ---------------------------------------------------------------------------
// cube_face_sphere_vertex_gen
// Maps a grid cell of a cube face onto the unit sphere as two triangles.
// ---------------------------------------------------------------------------
// Each accepted cell yields six vertices, one per cycle while the output is not
// stalled; the next cell can be taken while the last vertex of the previous one is
// issued. Cells outside the grid or sent with an unused face code are dropped.
// Each vertex passes through the front end, the one-bit-per-stage
// divider and the 16-stage square root. The whole pipeline holds while a
// finished vertex waits at the output.
`default_nettype none

module cube_face_sphere_vertex_gen #(
  parameter int MAX_DIVISIONS   = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  cfsv_cell_if.sink       cell_i,
  cfsv_vtx_if.source      vtx_o
);
  import cfsv_pkg::*;

  localparam int QW  = 2 * COORD_FRAC_BITS + 1;
  localparam int LAT = FRONT_LAT + QW + SQRT_LAT;

  logic [7:0] grid_div_q;
  logic [2:0] face_q;
  logic       en;

  vtx_coord_t            coord;
  vtx_meta_t             meta;
  vtx_meta_t             m_q [LAT];
  logic [2:0][NUM_W-1:0] num;
  logic [DEN_W-1:0]      den;
  logic [2:0]            neg_f, neg_d;
  logic [2:0][QW-1:0]    quo;
  logic signed [2:0][15:0] pos;

  vtx_meta_t          out_meta_q;
  logic signed [15:0] pos_x_q, pos_y_q, pos_z_q;

  assign en = !out_meta_q.valid || vtx_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_div_q <= 8'd0;
      face_q     <= FACE_FRONT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_DIV: grid_div_q <= cfg_data_i;
        REG_FACE:     face_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  cfsv_seq #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .grid_div_i (grid_div_q),
    .face_i     (face_q),
    .cell_i     (cell_i),
    .coord_o    (coord),
    .meta_o     (meta)
  );

  cfsv_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (coord),
    .num_o   (num),
    .den_o   (den),
    .neg_o   (neg_f)
  );

  cfsv_div #(.QW(QW)) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num),
    .den_i (den),
    .neg_i (neg_f),
    .quo_o (quo),
    .neg_o (neg_d)
  );

  cfsv_sqrt #(.QW(QW)) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .quo_i (quo),
    .neg_i (neg_d),
    .pos_o (pos)
  );

  // vertex tags ride alongside the arithmetic lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) m_q[s] <= '0;
      out_meta_q <= '0;
    end else if (en) begin
      m_q[0] <= meta;
      for (int s = 1; s < LAT; s++) m_q[s] <= m_q[s-1];
      out_meta_q <= m_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q <= pos[0];
      pos_y_q <= pos[1];
      pos_z_q <= pos[2];
    end
  end

  assign vtx_o.valid        = out_meta_q.valid;
  assign vtx_o.pos_x        = pos_x_q;
  assign vtx_o.pos_y        = pos_y_q;
  assign vtx_o.pos_z        = pos_z_q;
  assign vtx_o.tri_index    = out_meta_q.tri_idx;
  assign vtx_o.corner_index = out_meta_q.corner;
  assign vtx_o.last_vertex  = out_meta_q.last;

`ifndef SYNTH
  a_last_is_corner2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_o.valid && vtx_o.last_vertex) |-> (vtx_o.tri_index && vtx_o.corner_index == 2'd2))
    else $error("last vertex word not at second triangle, third corner");

  a_corner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_o.valid |-> (vtx_o.corner_index != 2'd3))
    else $error("corner index out of range");

  a_stall_holds_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(m_q[LAT-1]))
    else $error("pipeline tail moved during stall");
`endif

endmodule

`default_nettype wire

// File: hdl/cfsv_seq.sv
// ---------------------------------------------------------------------------
// cfsv_seq
// Cell sequencer: checks a cell and issues its six corner vertices.
// ---------------------------------------------------------------------------
`default_nettype none

module cfsv_seq #(
  parameter int MAX_DIVISIONS = 255
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic [7:0]          grid_div_i,
  input  wire logic [2:0]          face_i,
  cfsv_cell_if.sink                cell_i,
  output cfsv_pkg::vtx_coord_t     coord_o,
  output cfsv_pkg::vtx_meta_t      meta_o
);
  import cfsv_pkg::*;

  logic       busy_q, busy_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] row_q, col_q;
  logic [2:0] face_q;
  logic [8:0] n_q;

  logic [9:0] dc;
  logic       accept, cell_ok;
  logic [1:0] cc;
  logic [8:0] colp, rowp;
  logic signed [10:0] cn_w, rn_w;
  coord_t     cn, rn, plane;
  vtx_coord_t coord_d;
  vtx_meta_t  meta_d;

  assign dc = (10'(grid_div_i) > 10'(MAX_DIVISIONS)) ? 10'(MAX_DIVISIONS) : 10'(grid_div_i);
  assign cell_i.ready = !busy_q || (cnt_q == 3'd5 && en_i);
  assign accept = cell_i.valid && cell_i.ready;
  assign cell_ok = (face_i <= FACE_DOWN) && (10'(cell_i.cell_row) <= dc) &&
                   (10'(cell_i.cell_col) <= dc);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (en_i && busy_q) begin
      if (cnt_q == 3'd5) busy_d = 1'b0;
      else cnt_d = cnt_q + 3'd1;
    end
    if (accept && cell_ok) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cell_ok) begin
      row_q  <= cell_i.cell_row;
      col_q  <= cell_i.cell_col;
      face_q <= face_i;
      n_q    <= 9'(dc) + 9'd1;
    end
  end

  // corner of the current vertex, then its plane coordinates
  always_comb begin
    if (face_q == FACE_FRONT || face_q == FACE_RIGHT || face_q == FACE_DOWN) begin
      cc = WIND_A[cnt_q];
    end else begin
      cc = WIND_B[cnt_q];
    end
    colp  = 9'(col_q) + 9'(cc[0]);
    rowp  = 9'(row_q) + 9'(cc[1]);
    cn_w  = $signed({1'b0, colp, 1'b0}) - $signed({2'b0, n_q});
    rn_w  = $signed({1'b0, rowp, 1'b0}) - $signed({2'b0, n_q});
    cn    = cn_w[9:0];
    rn    = rn_w[9:0];
    if (face_q == FACE_BACK || face_q == FACE_RIGHT || face_q == FACE_UP) begin
      plane = $signed({1'b0, n_q});
    end else begin
      plane = -$signed({1'b0, n_q});
    end
    coord_d.n = n_q;
    case (face_q)
      FACE_FRONT, FACE_BACK: begin
        coord_d.px = cn; coord_d.py = rn; coord_d.pz = plane;
      end
      FACE_LEFT, FACE_RIGHT: begin
        coord_d.px = plane; coord_d.py = rn; coord_d.pz = cn;
      end
      default: begin
        coord_d.px = rn; coord_d.py = plane; coord_d.pz = cn;
      end
    endcase
    meta_d.valid   = busy_q;
    meta_d.tri_idx = (cnt_q >= 3'd3);
    meta_d.last    = (cnt_q == 3'd5);
    case (cnt_q)
      3'd0, 3'd3: meta_d.corner = 2'd0;
      3'd1, 3'd4: meta_d.corner = 2'd1;
      default:    meta_d.corner = 2'd2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_o <= '0;
    end else if (en_i) begin
      meta_o <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) coord_o <= coord_d;
  end

endmodule

`default_nettype wire

// File: hdl/cfsv_front.sv
// ---------------------------------------------------------------------------
// cfsv_front
// Five stage front end: root argument numerator and denominator per axis.
// ---------------------------------------------------------------------------
`default_nettype none

module cfsv_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire cfsv_pkg::vtx_coord_t                 coord_i,
  output logic [2:0][cfsv_pkg::NUM_W-1:0]           num_o,
  output logic [cfsv_pkg::DEN_W-1:0]                den_o,
  output logic [2:0]                                neg_o
);
  import cfsv_pkg::*;

  coord_t     c [3];
  logic [8:0] mag [3];

  // stage registers
  logic [2:0][16:0] p2_1_q, p2_2_q, p2_3_q, p2_4_q;
  logic [2:0]       neg_1_q, neg_2_q, neg_3_q, neg_4_q;
  logic [16:0]      n2_1_q, n2_2_q;
  logic [32:0]      n4_2_q, n4_3_q;
  logic [48:0]      n6_3_q;
  logic [2:0][17:0] sum_2_q;
  logic [2:0][33:0] prod_2_q, prod_3_q, t_3_q;
  logic [2:0][35:0] s_4_q;
  logic [DEN_W-1:0] den_4_q;
  logic signed [37:0] s_full [3];

  assign c[0] = coord_i.px;
  assign c[1] = coord_i.py;
  assign c[2] = coord_i.pz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i][9] ? 9'(-c[i]) : c[i][8:0];
      s_full[i] = $signed(38'(n4_3_q) * 38'd6) - $signed(38'(t_3_q[i]) * 38'd3) +
                  $signed(38'(prod_3_q[i]) * 38'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_1_q <= 17'(coord_i.n) * 17'(coord_i.n);
      n4_2_q <= 33'(n2_1_q) * 33'(n2_1_q);
      n2_2_q <= n2_1_q;
      n6_3_q <= 49'(n4_2_q) * 49'(n2_2_q);
      n4_3_q <= n4_2_q;
      den_4_q <= DEN_W'(n6_3_q) * DEN_W'(6);
      p2_2_q <= p2_1_q;
      p2_3_q <= p2_2_q;
      p2_4_q <= p2_3_q;
      neg_2_q <= neg_1_q;
      neg_3_q <= neg_2_q;
      neg_4_q <= neg_3_q;
      neg_o   <= neg_4_q;
      den_o   <= den_4_q;
      for (int i = 0; i < 3; i++) begin
        p2_1_q[i]   <= 17'(mag[i]) * 17'(mag[i]);
        neg_1_q[i]  <= c[i][9];
        sum_2_q[i]  <= 18'(p2_1_q[(i + 1) % 3]) + 18'(p2_1_q[(i + 2) % 3]);
        prod_2_q[i] <= 34'(p2_1_q[(i + 1) % 3]) * 34'(p2_1_q[(i + 2) % 3]);
        t_3_q[i]    <= 34'(n2_2_q) * 34'(sum_2_q[i]);
        prod_3_q[i] <= prod_2_q[i];
        // non-positive root argument gives zero
        s_4_q[i]    <= (s_full[i] > 0) ? s_full[i][35:0] : 36'd0;
        num_o[i]    <= NUM_W'(p2_4_q[i]) * NUM_W'(s_4_q[i]);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/cfsv_div.sv
// ---------------------------------------------------------------------------
// cfsv_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module cfsv_div #(
  parameter int QW = 29
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic [2:0][cfsv_pkg::NUM_W-1:0]      num_i,
  input  wire logic [cfsv_pkg::DEN_W-1:0]           den_i,
  input  wire logic [2:0]                           neg_i,
  output logic [2:0][QW-1:0]                        quo_o,
  output logic [2:0]                                neg_o
);
  import cfsv_pkg::*;

  logic [DEN_W-1:0]       den_q [QW];
  logic [2:0][NUM_W-1:0]  rem_q [QW];
  logic [2:0][NUM_W-1:0]  rem_d [QW];
  logic [2:0][QW-1:0]     quo_q [QW];
  logic [2:0][QW-1:0]     quo_d [QW];
  logic [2:0]             neg_q [QW];
  logic [NUM_W-1:0]       r2;
  logic                   ge;

  // numerator never exceeds the denominator, so the integer part is one bit
  always_comb begin
    for (int s = 0; s < QW; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (s == 0) begin
          r2 = num_i[i];
          ge = (r2 >= NUM_W'(den_i));
          rem_d[s][i] = ge ? r2 - NUM_W'(den_i) : r2;
          quo_d[s][i] = QW'(ge);
        end else begin
          r2 = {rem_q[s-1][i][NUM_W-2:0], 1'b0};
          ge = (r2 >= NUM_W'(den_q[s-1]));
          rem_d[s][i] = ge ? r2 - NUM_W'(den_q[s-1]) : r2;
          quo_d[s][i] = {quo_q[s-1][i][QW-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        den_q[s] <= (s == 0) ? den_i : den_q[(s == 0) ? 0 : s - 1];
        neg_q[s] <= (s == 0) ? neg_i : neg_q[(s == 0) ? 0 : s - 1];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[QW-1];
  assign neg_o = neg_q[QW-1];

endmodule

`default_nettype wire

// File: hdl/cfsv_sqrt.sv
// ---------------------------------------------------------------------------
// cfsv_sqrt
// Pipelined integer square root with saturation and sign, three lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module cfsv_sqrt #(
  parameter int QW = 29
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [2:0][QW-1:0]      quo_i,
  input  wire logic [2:0]              neg_i,
  output logic signed [2:0][15:0]      pos_o
);
  import cfsv_pkg::*;

  localparam int NIT = SQRT_LAT - 1;

  logic [2:0][30:0] v_q   [SQRT_LAT];
  logic [2:0][30:0] v_d   [SQRT_LAT];
  logic [2:0][30:0] res_q [SQRT_LAT];
  logic [2:0][30:0] res_d [SQRT_LAT];
  logic [2:0]       sat_q [SQRT_LAT];
  logic [2:0]       neg_q [SQRT_LAT];
  logic [2:0]       sat_d;
  logic [60:0]      qx;
  logic [30:0]      bitv, trial;
  logic [15:0]      mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx = 61'(quo_i[i]);
      sat_d[i] = |qx[60:30];
      v_d[0][i] = {1'b0, qx[29:0]};
      res_d[0][i] = '0;
    end
    for (int s = 1; s < SQRT_LAT; s++) begin
      bitv = 31'(1) << (2 * (NIT - s));
      for (int i = 0; i < 3; i++) begin
        trial = res_q[s-1][i] + bitv;
        if (v_q[s-1][i] >= trial) begin
          v_d[s][i]   = v_q[s-1][i] - trial;
          res_d[s][i] = (res_q[s-1][i] >> 1) + bitv;
        end else begin
          v_d[s][i]   = v_q[s-1][i];
          res_d[s][i] = res_q[s-1][i] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_LAT; s++) begin
        v_q[s]   <= v_d[s];
        res_q[s] <= res_d[s];
        sat_q[s] <= (s == 0) ? sat_d : sat_q[(s == 0) ? 0 : s - 1];
        neg_q[s] <= (s == 0) ? neg_i : neg_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag = sat_q[SQRT_LAT-1][i] ? SAT_MAG : res_q[SQRT_LAT-1][i][15:0];
      pos_o[i] = neg_q[SQRT_LAT-1][i] ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/cube_face_sphere_vertex_gen_tb.sv
// ---------------------------------------------------------------------------
// cube_face_sphere_vertex_gen_tb
// Self-checking bench: drives grid cells on the cell channel under several
// grid sizes and faces and checks every vertex word against an exact
// integer model of the cube-to-sphere mapping and triangle winding.
// ---------------------------------------------------------------------------
`default_nettype none

module cube_face_sphere_vertex_gen_tb;
  import cfsv_pkg::*;

  localparam int FRAC = 14;
  localparam int DRAIN_CYC = 80;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic               tri_i;
    logic [1:0]         cor;
    logic               last;
  } vert_t;

  typedef struct {
    logic [7:0] div;
    logic [2:0] face;
    logic [7:0] row;
    logic [7:0] col;
    bit         unit_mag;  // one-cell face: every component is 1/sqrt(3)
  } cell_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = 8'd0;

  cfsv_cell_if cell_bus ();
  cfsv_vtx_if  vtx_bus ();

  cube_face_sphere_vertex_gen dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cell_i     (cell_bus),
    .vtx_o      (vtx_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    cell_bus.valid    = 1'b0;
    cell_bus.cell_row = 8'd0;
    cell_bus.cell_col = 8'd0;
    vtx_bus.ready     = 1'b0;
  end

  logic [7:0] grid_div = 8'd0;
  logic [2:0] face_sel = FACE_FRONT;
  vert_t      vert_q[$];
  int         mismatches = 0;
  int         verts_seen = 0;
  int         cells_sent = 0;
  int         cells_dropped = 0;
  bit         idle_en = 1'b1;
  bit         hold_req = 1'b0;

  // one mapped component, truncated toward zero, saturated
  function automatic logic signed [15:0] sphere_axis(longint p, longint q, longint r,
                                                     longint n);
    longint          n2, s;
    longint unsigned mag, num, den;
    bit [127:0]      x;
    logic [15:0]     root;
    n2 = n * n;
    s = 6 * n2 * n2 - 3 * n2 * (q * q + r * r) + 2 * q * q * r * r;
    if (p == 0 || s <= 0) return 16'sd0;
    mag = (p < 0) ? -p : p;
    num = mag * mag * s;
    den = 6 * n2 * n2 * n2;
    x = ({64'd0, num} << (2 * FRAC)) / den;
    if (x >= (128'd1 << 30)) begin
      root = SAT_MAG;
    end else begin
      root = '0;
      for (int i = 14; i >= 0; i--)
        if ((root | (16'd1 << i)) * (root | (16'd1 << i)) <= x) root |= 16'd1 << i;
    end
    return (p < 0) ? -$signed(root) : $signed(root);
  endfunction

  task automatic push_cell_verts(logic [7:0] row, logic [7:0] col, bit unit_mag);
    longint n, plane, cn, rn, px, py, pz;
    logic [1:0] cc;
    vert_t v;
    if (face_sel > FACE_DOWN || row > grid_div || col > grid_div) begin
      cells_dropped++;
      return;
    end
    n = grid_div + 1;
    plane = (face_sel == FACE_BACK || face_sel == FACE_RIGHT || face_sel == FACE_UP)
            ? n : -n;
    for (int k = 0; k < 6; k++) begin
      cc = (face_sel == FACE_FRONT || face_sel == FACE_RIGHT || face_sel == FACE_DOWN)
           ? WIND_A[k] : WIND_B[k];
      cn = 2 * (col + cc[0]) - n;
      rn = 2 * (row + cc[1]) - n;
      if (face_sel <= FACE_BACK) begin
        px = cn; py = rn; pz = plane;
      end else if (face_sel <= FACE_RIGHT) begin
        px = plane; py = rn; pz = cn;
      end else begin
        px = rn; py = plane; pz = cn;
      end
      v.x = sphere_axis(px, py, pz, n);
      v.y = sphere_axis(py, pz, px, n);
      v.z = sphere_axis(pz, px, py, n);
      if (unit_mag) begin
        v.x = (px < 0) ? -16'sd9459 : 16'sd9459;
        v.y = (py < 0) ? -16'sd9459 : 16'sd9459;
        v.z = (pz < 0) ? -16'sd9459 : 16'sd9459;
      end
      v.tri_i = (k >= 3);
      v.cor   = 2'(k % 3);
      v.last  = (k == 5);
      vert_q.push_back(v);
    end
  endtask

  // vertex checker
  always @(posedge clk_i) begin
    vert_t e;
    if (rst_ni && vtx_bus.valid && vtx_bus.ready) begin
      verts_seen++;
      if (vert_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex word at %0t", $realtime);
      end else begin
        e = vert_q.pop_front();
        if (vtx_bus.pos_x !== e.x || vtx_bus.pos_y !== e.y || vtx_bus.pos_z !== e.z ||
            vtx_bus.tri_index !== e.tri_i || vtx_bus.corner_index !== e.cor ||
            vtx_bus.last_vertex !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: exp %0d %0d %0d t%0d c%0d l%0d got %0d %0d %0d t%0d c%0d l%0d",
                     e.x, e.y, e.z, e.tri_i, e.cor, e.last, vtx_bus.pos_x, vtx_bus.pos_y,
                     vtx_bus.pos_z, vtx_bus.tri_index, vtx_bus.corner_index,
                     vtx_bus.last_vertex);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        vtx_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        vtx_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        vtx_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic wait_idle();
    wait (vert_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [7:0] div, logic [2:0] face);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_GRID_DIV;
    cfg_data_i <= div;
    @(posedge clk_i);
    grid_div = div;
    cfg_idx_i  <= REG_FACE;
    cfg_data_i <= {5'($urandom), face};  // upper bits are don't-care
    @(posedge clk_i);
    face_sel = face;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cell(logic [7:0] row, logic [7:0] col, bit unit_mag);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      cell_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    cell_bus.valid    <= 1'b1;
    cell_bus.cell_row <= row;
    cell_bus.cell_col <= col;
    do @(posedge clk_i); while (!cell_bus.ready);
    cells_sent++;
    push_cell_verts(row, col, unit_mag);
  endtask

  task automatic drop_valid();
    cell_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  cell_row_t directed[] = '{
    '{8'd0, FACE_FRONT, 8'd0, 8'd0, 1'b1}, '{8'd0, FACE_BACK,  8'd0, 8'd0, 1'b1},
    '{8'd0, FACE_LEFT,  8'd0, 8'd0, 1'b1}, '{8'd0, FACE_RIGHT, 8'd0, 8'd0, 1'b1},
    '{8'd0, FACE_UP,    8'd0, 8'd0, 1'b1}, '{8'd0, FACE_DOWN,  8'd0, 8'd0, 1'b1},
    '{8'd0, FACE_FRONT, 8'd1, 8'd0, 1'b0}, '{8'd0, FACE_FRONT, 8'd0, 8'd1, 1'b0},
    '{8'd0, 3'd6,       8'd0, 8'd0, 1'b0}, '{8'd0, 3'd7,       8'd0, 8'd0, 1'b0},
    '{8'd255, FACE_FRONT, 8'd0,   8'd0,   1'b0},
    '{8'd255, FACE_FRONT, 8'd255, 8'd255, 1'b0},
    '{8'd255, FACE_FRONT, 8'd0,   8'd255, 1'b0},
    '{8'd255, FACE_FRONT, 8'd255, 8'd0,   1'b0},
    '{8'd255, FACE_FRONT, 8'd128, 8'd127, 1'b0},
    '{8'd255, FACE_RIGHT, 8'd255, 8'd255, 1'b0},
    '{8'd255, FACE_LEFT,  8'd170, 8'd85,  1'b0},
    '{8'd255, FACE_UP,    8'd85,  8'd170, 1'b0},
    '{8'd255, FACE_DOWN,  8'd255, 8'd0,   1'b0},
    '{8'd1, FACE_BACK, 8'd1, 8'd1, 1'b0}, '{8'd1, FACE_BACK, 8'd2, 8'd0, 1'b0},
    '{8'd1, FACE_BACK, 8'd0, 8'd2, 1'b0}
  };

  initial begin
    logic [7:0] div, r, c;
    logic [2:0] face;
    int         n_cells;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].div != grid_div || directed[i].face != face_sel) begin
        drop_valid();
        wait_idle();
        set_cfg(directed[i].div, directed[i].face);
      end
      send_cell(directed[i].row, directed[i].col, directed[i].unit_mag);
    end

    for (int ph = 0; ph < 11; ph++) begin
      drop_valid();
      wait_idle();
      case (ph)
        0: div = 8'd0;
        1: div = 8'd1;
        2: div = 8'd3;
        3, 4: div = 8'd255;
        5: div = 8'd7;
        default: div = 8'($urandom_range(0, 255));
      endcase
      face = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      if (ph == 3) face = FACE_FRONT;
      set_cfg(div, face);
      if (ph == 4) hold_req = 1'b1;  // long output stall to back up the pipe
      if (ph == 10) idle_en = 1'b0;
      n_cells = (face > FACE_DOWN) ? 10 : 44;
      for (int k = 0; k < n_cells; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = 8'($urandom);
          c = 8'($urandom);
        end else begin
          r = 8'($urandom_range(0, div));
          c = 8'($urandom_range(0, div));
        end
        send_cell(r, c, 1'b0);
      end
    end

    drop_valid();
    wait_idle();
    $display("%0d cells sent (%0d dropped), %0d vertex words checked over all faces",
             cells_sent, cells_dropped, verts_seen);
    $display("grid sizes from one cell to 256 per side, with random and long stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout, %0d vertex words still expected", vert_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
